// ----- rtl/seven_segment_scan_writer_assert.svh -----
// Assertion macros shared by the seven-segment scan writer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SEVEN_SEGMENT_SCAN_WRITER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_WRITER_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define SSSW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SSSW_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/sssw_pkg.sv -----
// Shared types, codes and the segment font for the seven-segment scan writer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sssw_pkg;

	// Request codes on the input channel
	localparam logic [1:0] REQ_DEC   = 2'd0;
	localparam logic [1:0] REQ_HEX   = 2'd1;
	localparam logic [1:0] REQ_BLANK = 2'd2;

	localparam int VALUE_W = 16;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 2;

	// Divide by ten: q = (v * DEC_RECIP) >> DEC_SHIFT is exact for 16-bit v
	localparam logic [VALUE_W-1:0] DEC_RECIP = 16'd52429;
	localparam int                 DEC_SHIFT = 19;

	// Latch select codes
	localparam logic LATCH_FONT = 1'b0;
	localparam logic LATCH_POS  = 1'b1;

	// Position byte for digit zero; shifted right by the digit index
	localparam logic [BYTE_W-1:0] POS_BASE = 8'h08;

	typedef enum logic [1:0] {
		KIND_DEC,
		KIND_HEX,
		KIND_BLANK
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
	} item_t;

	// Inverted segment pattern (active-low display, bit 0 = segment a)
	function automatic logic [BYTE_W-1:0] font_byte(input logic [3:0] digit);
		logic [BYTE_W-1:0] seg;
		case (digit)
			4'h0: seg = 8'h3F;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5B;
			4'h3: seg = 8'h4F;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6D;
			4'h6: seg = 8'h7D;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7F;
			4'h9: seg = 8'h6F;
			4'hA: seg = 8'h77;
			4'hB: seg = 8'h7C;
			4'hC: seg = 8'h39;
			4'hD: seg = 8'h5E;
			4'hE: seg = 8'h79;
			4'hF: seg = 8'h71;
			default: seg = 8'h00;
		endcase
		return ~seg;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sssw_front.sv -----
// Front end: accepts requests, classifies them and queues them two deep.
// Depends on sssw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sssw_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  req_type,
	input  wire logic [sssw_pkg::VALUE_W-1:0] value,
	output logic                             q_valid,
	output sssw_pkg::item_t                  q_item,
	input  wire logic                        q_pop
);

	sssw_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            keep;
	logic            push;
	sssw_pkg::item_t classified;

	// Classify the request; the unused code is taken and dropped
	always_comb begin
		keep             = 1'b1;
		classified.value = value;
		classified.kind  = sssw_pkg::KIND_DEC;
		case (req_type)
			sssw_pkg::REQ_DEC:   classified.kind = sssw_pkg::KIND_DEC;
			sssw_pkg::REQ_HEX:   classified.kind = sssw_pkg::KIND_HEX;
			sssw_pkg::REQ_BLANK: classified.kind = sssw_pkg::KIND_BLANK;
			default:             keep            = 1'b0;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	// Write the queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sssw_back.sv -----
// Back end: walks the digits of one queued request and emits latch-write beats.
// Depends on sssw_pkg and seven_segment_scan_writer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_scan_writer_assert.svh"

module sssw_back #(
	parameter int DIGITS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire sssw_pkg::item_t             q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             latch_select,
	output logic [sssw_pkg::BYTE_W-1:0]      bus_byte,
	output logic                             last
);

	localparam logic [sssw_pkg::IDX_W-1:0] LAST_IDX = sssw_pkg::IDX_W'(DIGITS - 1);

	logic                            busy_q;
	sssw_pkg::kind_t                 kind_q;
	logic [sssw_pkg::VALUE_W-1:0]    val_q;
	logic [sssw_pkg::IDX_W-1:0]      idx_q;
	logic                            phase_q;

	logic                            out_valid_q;
	logic                            sel_q;
	logic [sssw_pkg::BYTE_W-1:0]     byte_q;
	logic                            last_q;

	logic                            out_load;
	logic                            advance;
	logic                            done;
	logic [2*sssw_pkg::VALUE_W-1:0]  prod;
	logic [12:0]                     quot10;
	logic [16:0]                     times10;
	logic [3:0]                      digit;
	logic [sssw_pkg::VALUE_W-1:0]    next_val;
	logic                            beat_sel;
	logic [sssw_pkg::BYTE_W-1:0]     beat_byte;
	logic                            beat_last;

	assign out_load = !out_valid_q || out_ready;
	assign advance  = busy_q && out_load;
	assign done     = phase_q && ((kind_q == sssw_pkg::KIND_BLANK) || (idx_q == LAST_IDX));
	assign q_pop    = q_valid && (!busy_q || (advance && done));

	// Split off the low digit in the chosen base
	assign prod    = val_q * sssw_pkg::DEC_RECIP;
	assign quot10  = prod[sssw_pkg::DEC_SHIFT +: 13];
	assign times10 = {1'b0, quot10, 3'b000} + {3'b000, quot10, 1'b0};

	always_comb begin
		if (kind_q == sssw_pkg::KIND_HEX) begin
			digit    = val_q[3:0];
			next_val = {4'h0, val_q[sssw_pkg::VALUE_W-1:4]};
		end else begin
			digit    = val_q[3:0] - times10[3:0];
			next_val = {3'b000, quot10};
		end
	end

	// Form the beat for the current phase
	always_comb begin
		if (kind_q == sssw_pkg::KIND_BLANK) begin
			beat_sel  = phase_q ? sssw_pkg::LATCH_FONT : sssw_pkg::LATCH_POS;
			beat_byte = '0;
			beat_last = phase_q;
		end else if (!phase_q) begin
			beat_sel  = sssw_pkg::LATCH_FONT;
			beat_byte = sssw_pkg::font_byte(digit);
			beat_last = 1'b0;
		end else begin
			beat_sel  = sssw_pkg::LATCH_POS;
			beat_byte = sssw_pkg::POS_BASE >> idx_q;
			beat_last = (idx_q == LAST_IDX);
		end
	end

	// Sequence through font and position beats per digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_pop) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			phase_q <= ~phase_q;
			if (done) begin
				busy_q <= 1'b0;
			end else if (phase_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Load the request payload or step the value down one digit
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_item.kind;
			val_q  <= q_item.value;
		end else if (advance && phase_q) begin
			val_q <= next_val;
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sel_q  <= beat_sel;
			byte_q <= beat_byte;
			last_q <= beat_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign latch_select = sel_q;
	assign bus_byte     = byte_q;
	assign last         = last_q;

	`SSSW_ASSERT(a_idx_range, clk, arst_n, busy_q |-> (idx_q <= LAST_IDX),
		"digit index past last digit")
	`SSSW_ASSERT(a_blank_zero, clk, arst_n,
		(advance && kind_q == sssw_pkg::KIND_BLANK) |=> (byte_q == '0),
		"blank beat carries nonzero byte")
	`SSSW_ASSERT(a_pos_onehot, clk, arst_n,
		(advance && phase_q && kind_q != sssw_pkg::KIND_BLANK) |=> $onehot(byte_q),
		"position beat not one-hot")
	`SSSW_ASSERT(a_done_idle, clk, arst_n, (advance && done && !q_pop) |=> !busy_q,
		"sequencer busy after final beat")

endmodule

`default_nettype wire

// ----- rtl/seven_segment_scan_writer.sv -----
// Top level of the seven-segment scan writer: front queue plus beat sequencer.
// Depends on sssw_pkg, sssw_front and sssw_back.
//
//   channel | signals                                  | role
//   --------+------------------------------------------+------------------------------
//   in      | in_valid, in_ready, req_type, value      | one display request per beat
//   out     | out_valid, out_ready, latch_select,      | one latch write per beat,
//           | bus_byte, last                           | last marks end of request
//
// A show request yields 2*DIGITS beats, a blank request two, code 3 none.
// The back sequencer emits one beat per cycle while the output is not stalled, so a show
// request occupies it for 2*DIGITS beats; a two-entry queue lets the input keep accepting meanwhile.
// A request's first beat passes through its queue entry, the sequencer registers and the output register.
// Reset clears the queue, the sequencer and the output valid.
// A stalled output holds its beat and stops the sequencer; input stalls only when
// the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_writer #(
	parameter int DIGITS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   req_type,
	input  wire logic [sssw_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              latch_select,
	output logic [sssw_pkg::BYTE_W-1:0]       bus_byte,
	output logic                              last
);

	logic            q_valid;
	logic            q_pop;
	sssw_pkg::item_t q_item;

	// Accept and queue requests
	sssw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.value    (value),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Turn queued requests into latch-write beats
	sssw_back #(
		.DIGITS (DIGITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.latch_select (latch_select),
		.bus_byte     (bus_byte),
		.last         (last)
	);

endmodule

`default_nettype wire
